// ===== hw/rtl/pfh_pkg.sv =====
`timescale 1ns / 1ps

package pfh_pkg;

   // Built size and field widths.
   localparam int MAX_OCTAVES = 8;
   localparam int COORD_BITS  = 12;
   localparam int COL_W       = 12;
   localparam int ROW_W       = 12;
   localparam int HEIGHT_W    = 26;
   localparam int SEED_W      = 8;
   localparam int FREQ_CFG_W  = 24;
   localparam int AMP_W       = 16;
   localparam int COUNT_W     = 4;

   // Internal formats.
   localparam int FRAC_W   = 16;
   localparam int LAT_W    = 8;
   localparam int POS_W    = LAT_W + FRAC_W;
   localparam int POS_LSB  = 9;
   localparam int FREQ_W   = FREQ_CFG_W + MAX_OCTAVES - 1;
   localparam int PROD_W   = COORD_BITS + FREQ_W;
   localparam int SCALE_W  = (PROD_W + 2 > POS_LSB + POS_W) ? PROD_W + 2 : POS_LSB + POS_W;
   localparam int REM_W    = $clog2(MAX_OCTAVES + 1);
   localparam int DOT_W    = 25;
   localparam int FADE_W   = 17;
   localparam int Q_W      = 20;
   localparam int SUM_W    = 30;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED           = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_FREQUENCY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_AMPLITUDE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERSISTENCE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OCTAVE_COUNT   = 3'd4;

   localparam logic [SEED_W-1:0]     SEED_RESET           = 8'd0;
   localparam logic [FREQ_CFG_W-1:0] BASE_FREQUENCY_RESET = 24'd167772;
   localparam logic [AMP_W-1:0]      BASE_AMPLITUDE_RESET = 16'd26214;
   localparam logic [AMP_W-1:0]      PERSISTENCE_RESET    = 16'd22938;
   localparam logic [COUNT_W-1:0]    OCTAVE_COUNT_RESET   = 4'd4;

   // A transaction as it travels from one octave cell to the next.
   typedef struct packed {
      logic [COORD_BITS-1:0]    column;
      logic [COORD_BITS-1:0]    row;
      logic [FREQ_W-1:0]        freq;
      logic [AMP_W-1:0]         amp;
      logic [REM_W-1:0]         remain;
      logic signed [SUM_W-1:0]  sum;
   } token_type;

   // Settings shared by every cell.
   typedef struct packed {
      logic [SEED_W-1:0] seed;
      logic [AMP_W-1:0]  persistence;
   } cfg_type;

   localparam logic [7:0] HASH_ROM [0:255] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
      8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
      8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
      8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
      8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
      8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
      8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
      8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
      8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
      8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
      8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
      8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
      8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
      8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
      8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
      8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
      8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
      8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
      8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
      8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

endpackage

// ===== hw/rtl/perlin_fbm_height_unit.sv =====
`timescale 1ns / 1ps
// Path: a request crosses all MAX_OCTAVES octave cells and then the output register; the
// built size has eight octaves. Throughput: one transaction per cycle while not stalled;
// every octave has its own cell, so no unit is shared.
// Reset: synchronous, active high; clears the valid bits and loads the registers' defaults.

// Fractal sum of 2D gradient noise. A request carries a pixel (column, row). It enters a
// chain of identical octave cells. Each cell is an eight stage pipeline that scales the
// sample point by its octave's frequency, hashes the four lattice corners through the
// permutation table, forms the corner dot products, blends them with the quintic fade and
// adds the amplitude-weighted noise to a running sum. The cell then passes the transaction
// on with the frequency doubled, the amplitude multiplied by the persistence and the count
// of octaves still to add decremented. Once that count reaches zero the later cells pass
// the sum through untouched. The last cell feeds a saturating output register.
//
// Flow control is a single pipeline enable. The chain moves unless the output register
// holds a stalled response and the last cell also has a finished transaction waiting;
// bubbles in the chain therefore keep closing up while the response side is stalled.
module perlin_fbm_height_unit (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pfh_pkg::COL_W-1:0]           req_column,
   input  logic [pfh_pkg::ROW_W-1:0]           req_row,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pfh_pkg::HEIGHT_W-1:0] rsp_height,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfh_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pfh_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam logic signed [pfh_pkg::SUM_W-1:0] SUM_HI =
      pfh_pkg::SUM_W'((64'sd1 <<< (pfh_pkg::HEIGHT_W - 1)) - 64'sd1);
   localparam logic signed [pfh_pkg::SUM_W-1:0] SUM_LO =
      pfh_pkg::SUM_W'(-(64'sd1 <<< (pfh_pkg::HEIGHT_W - 1)));

   // Configuration registers.
   logic [pfh_pkg::SEED_W-1:0]     seed_ff;
   logic [pfh_pkg::FREQ_CFG_W-1:0] base_frequency_ff;
   logic [pfh_pkg::AMP_W-1:0]      base_amplitude_ff;
   logic [pfh_pkg::AMP_W-1:0]      persistence_ff;
   logic [pfh_pkg::COUNT_W-1:0]    octave_count_ff;

   logic                           enable;
   pfh_pkg::cfg_type               cfg;
   pfh_pkg::token_type             head_tok;
   logic                           chain_valid [pfh_pkg::MAX_OCTAVES+1];
   pfh_pkg::token_type             chain_tok   [pfh_pkg::MAX_OCTAVES+1];
   logic signed [pfh_pkg::SUM_W-1:0] final_sum;
   logic signed [pfh_pkg::HEIGHT_W-1:0] height_in;
   logic                           rsp_valid_ff;
   logic signed [pfh_pkg::HEIGHT_W-1:0] rsp_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff           <= pfh_pkg::SEED_RESET;
         base_frequency_ff <= pfh_pkg::BASE_FREQUENCY_RESET;
         base_amplitude_ff <= pfh_pkg::BASE_AMPLITUDE_RESET;
         persistence_ff    <= pfh_pkg::PERSISTENCE_RESET;
         octave_count_ff   <= pfh_pkg::OCTAVE_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pfh_pkg::CSR_SEED: begin
               seed_ff <= csr_data[pfh_pkg::SEED_W-1:0];
            end
            pfh_pkg::CSR_BASE_FREQUENCY: begin
               base_frequency_ff <= csr_data[pfh_pkg::FREQ_CFG_W-1:0];
            end
            pfh_pkg::CSR_BASE_AMPLITUDE: begin
               base_amplitude_ff <= csr_data[pfh_pkg::AMP_W-1:0];
            end
            pfh_pkg::CSR_PERSISTENCE: begin
               persistence_ff <= csr_data[pfh_pkg::AMP_W-1:0];
            end
            pfh_pkg::CSR_OCTAVE_COUNT: begin
               octave_count_ff <= csr_data[pfh_pkg::COUNT_W-1:0];
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // The chain stops only when a finished transaction would overrun a stalled response.
   assign enable    = !(rsp_valid_ff && rsp_stall && chain_valid[pfh_pkg::MAX_OCTAVES]);
   assign req_stall = !enable;

   assign cfg.seed        = seed_ff;
   assign cfg.persistence = persistence_ff;

   always_comb begin
      head_tok.column = req_column[pfh_pkg::COORD_BITS-1:0];
      head_tok.row    = req_row[pfh_pkg::COORD_BITS-1:0];
      head_tok.freq   = pfh_pkg::FREQ_W'(base_frequency_ff);
      head_tok.amp    = base_amplitude_ff;
      // Counts above the built number of cells use every cell.
      if (32'(octave_count_ff) > pfh_pkg::MAX_OCTAVES) begin
         head_tok.remain = pfh_pkg::REM_W'(pfh_pkg::MAX_OCTAVES);
      end else begin
         head_tok.remain = pfh_pkg::REM_W'(octave_count_ff);
      end
      head_tok.sum    = '0;
   end

   assign chain_valid[0] = req_valid;
   assign chain_tok[0]   = head_tok;

   for (genvar g = 0; g < pfh_pkg::MAX_OCTAVES; g++) begin : g_octave
      pfh_octave_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .cfg       (cfg),
         .in_valid  (chain_valid[g]),
         .in_tok    (chain_tok[g]),
         .out_valid (chain_valid[g+1]),
         .out_tok   (chain_tok[g+1])
      );
   end

   // Saturate the exact sum once, at the end of the chain.
   always_comb begin
      final_sum = chain_tok[pfh_pkg::MAX_OCTAVES].sum;
      priority if (final_sum > SUM_HI) begin
         height_in = SUM_HI[pfh_pkg::HEIGHT_W-1:0];
      end else if (final_sum < SUM_LO) begin
         height_in = SUM_LO[pfh_pkg::HEIGHT_W-1:0];
      end else begin
         height_in = final_sum[pfh_pkg::HEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable && chain_valid[pfh_pkg::MAX_OCTAVES]) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && chain_valid[pfh_pkg::MAX_OCTAVES]) begin
         rsp_height_ff <= height_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = rsp_height_ff;

endmodule

// ===== hw/rtl/pfh_octave_cell.sv =====
`timescale 1ns / 1ps

// One octave of gradient noise, eight register stages deep. The cell adds its
// weighted noise to the running sum and hands the next octave's frequency,
// amplitude and remaining count to its neighbor.
module pfh_octave_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  pfh_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  pfh_pkg::token_type  in_tok,
   output logic                out_valid,
   output pfh_pkg::token_type  out_tok
);

   localparam int DX_W    = pfh_pkg::FRAC_W + 2;
   localparam int BLEND_W = pfh_pkg::FADE_W + pfh_pkg::DOT_W + 2;
   localparam int TERM_W  = pfh_pkg::AMP_W + 1 + pfh_pkg::DOT_W;
   localparam int CUBE_W  = 3 * pfh_pkg::FRAC_W;
   localparam int QF_W    = 37;
   localparam int STAGES  = 8;

   function automatic logic signed [pfh_pkg::DOT_W-1:0] corner_dot(
      input logic [7:0]              h,
      input logic signed [DX_W-1:0]  dx,
      input logic signed [DX_W-1:0]  dy
   );
      logic signed [pfh_pkg::DOT_W-1:0] gx;
      logic signed [pfh_pkg::DOT_W-1:0] gy;
      logic signed [pfh_pkg::DOT_W-1:0] px;
      logic signed [pfh_pkg::DOT_W-1:0] py;
      gx = $signed(pfh_pkg::DOT_W'({h[7:4], 1'b0})) - pfh_pkg::DOT_W'(1);
      gy = $signed(pfh_pkg::DOT_W'({h[3:0], 1'b0})) - pfh_pkg::DOT_W'(1);
      px = gx * pfh_pkg::DOT_W'(dx);
      py = gy * pfh_pkg::DOT_W'(dy);
      return px + py;
   endfunction

   // a + floor(s * (b - a) / 2^16)
   function automatic logic signed [pfh_pkg::DOT_W-1:0] blend(
      input logic signed [pfh_pkg::DOT_W-1:0] a,
      input logic signed [pfh_pkg::DOT_W-1:0] b,
      input logic [pfh_pkg::FADE_W-1:0]       s
   );
      logic signed [BLEND_W-1:0] diff;
      logic signed [BLEND_W-1:0] prod;
      logic signed [BLEND_W-1:0] step;
      diff = BLEND_W'(b) - BLEND_W'(a);
      prod = $signed(BLEND_W'(s)) * diff;
      step = prod >>> pfh_pkg::FRAC_W;
      return a + step[pfh_pkg::DOT_W-1:0];
   endfunction

   logic                 vld_ff [STAGES];
   pfh_pkg::token_type   tok_ff [STAGES-1];

   // Stage 1: coordinate times frequency.
   logic [pfh_pkg::PROD_W-1:0] prod_x_ff, prod_y_ff;
   // Stage 2: lattice position.
   logic [pfh_pkg::SCALE_W-1:0] scale_x, scale_y;
   logic [pfh_pkg::POS_W-1:0]   pos_x_ff, pos_y_ff;
   // Stage 3: first hash level and squares.
   logic [7:0]                  ix_lo, ix_hi;
   logic [7:0]                  hash_lo_ff, hash_hi_ff, iy3_ff;
   logic [pfh_pkg::FRAC_W-1:0]  tx3_ff, ty3_ff;
   logic [2*pfh_pkg::FRAC_W-1:0] t2x3_ff, t2y3_ff;
   // Stage 4: corner hashes and fade factors.
   logic [7:0]                  iy_lo, iy_hi;
   logic [7:0]                  h00_ff, h10_ff, h01_ff, h11_ff;
   logic [pfh_pkg::FRAC_W-1:0]  tx4_ff, ty4_ff;
   logic [CUBE_W-1:0]           cube_x, cube_y;
   logic [QF_W-1:0]             qf_x, qf_y;
   logic [pfh_pkg::FRAC_W-1:0]  cx4_ff, cy4_ff;
   logic [pfh_pkg::Q_W-1:0]     qx4_ff, qy4_ff;
   // Stage 5: dot products and fade.
   logic [pfh_pkg::FRAC_W+pfh_pkg::Q_W-1:0] fade_x, fade_y;
   logic signed [DX_W-1:0]      dx0, dx1, dy0, dy1;
   logic signed [pfh_pkg::DOT_W-1:0] d00_ff, d10_ff, d01_ff, d11_ff;
   logic [pfh_pkg::FADE_W-1:0]  sx5_ff, sy5_ff, sy6_ff;
   // Stages 6 and 7: blends.
   logic signed [pfh_pkg::DOT_W-1:0] r0_ff, r1_ff, noise_ff;
   // Stage 8: weighting and amplitude update.
   logic signed [TERM_W-1:0]    term_full, term;
   logic [2*pfh_pkg::AMP_W-1:0] amp_prod;
   logic [pfh_pkg::AMP_W:0]     amp_scaled;
   pfh_pkg::token_type          last_tok, out_tok_in, out_tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_comb begin
      scale_x = pfh_pkg::SCALE_W'({prod_x_ff, 1'b0}) + pfh_pkg::SCALE_W'(tok_ff[0].freq);
      scale_y = pfh_pkg::SCALE_W'({prod_y_ff, 1'b0}) + pfh_pkg::SCALE_W'(tok_ff[0].freq);

      ix_lo = pos_x_ff[pfh_pkg::POS_W-1:pfh_pkg::FRAC_W] + cfg.seed;
      ix_hi = ix_lo + 8'd1;

      iy_lo = iy3_ff;
      iy_hi = iy3_ff + 8'd1;

      cube_x = CUBE_W'(t2x3_ff) * CUBE_W'(tx3_ff);
      cube_y = CUBE_W'(t2y3_ff) * CUBE_W'(ty3_ff);
      qf_x = (QF_W'(10) << 32) + QF_W'(t2x3_ff) * QF_W'(6)
             - ((QF_W'(tx3_ff) * QF_W'(15)) << pfh_pkg::FRAC_W);
      qf_y = (QF_W'(10) << 32) + QF_W'(t2y3_ff) * QF_W'(6)
             - ((QF_W'(ty3_ff) * QF_W'(15)) << pfh_pkg::FRAC_W);

      fade_x = (pfh_pkg::FRAC_W + pfh_pkg::Q_W)'(cx4_ff)
               * (pfh_pkg::FRAC_W + pfh_pkg::Q_W)'(qx4_ff);
      fade_y = (pfh_pkg::FRAC_W + pfh_pkg::Q_W)'(cy4_ff)
               * (pfh_pkg::FRAC_W + pfh_pkg::Q_W)'(qy4_ff);
      // Offsets to the near and far corner: t and t - 1.
      dx0 = $signed({2'b00, tx4_ff});
      dx1 = $signed({2'b11, tx4_ff});
      dy0 = $signed({2'b00, ty4_ff});
      dy1 = $signed({2'b11, ty4_ff});

      last_tok  = tok_ff[STAGES-2];
      term_full = $signed(TERM_W'(last_tok.amp)) * TERM_W'(noise_ff);
      term      = term_full >>> 15;
      amp_prod  = (2*pfh_pkg::AMP_W)'(last_tok.amp) * (2*pfh_pkg::AMP_W)'(cfg.persistence);
      amp_scaled = amp_prod[2*pfh_pkg::AMP_W-1:15];

      out_tok_in = last_tok;
      out_tok_in.freq = {last_tok.freq[pfh_pkg::FREQ_W-2:0], 1'b0};
      if (amp_scaled[pfh_pkg::AMP_W]) begin
         out_tok_in.amp = '1;
      end else begin
         out_tok_in.amp = amp_scaled[pfh_pkg::AMP_W-1:0];
      end
      if (last_tok.remain != '0) begin
         out_tok_in.remain = last_tok.remain - 1'b1;
         out_tok_in.sum    = last_tok.sum + pfh_pkg::SUM_W'(term);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tok_ff[0] <= in_tok;
         for (int k = 1; k < STAGES - 1; k++) begin
            tok_ff[k] <= tok_ff[k-1];
         end

         prod_x_ff <= pfh_pkg::PROD_W'(in_tok.column) * pfh_pkg::PROD_W'(in_tok.freq);
         prod_y_ff <= pfh_pkg::PROD_W'(in_tok.row) * pfh_pkg::PROD_W'(in_tok.freq);

         pos_x_ff <= scale_x[pfh_pkg::POS_LSB +: pfh_pkg::POS_W];
         pos_y_ff <= scale_y[pfh_pkg::POS_LSB +: pfh_pkg::POS_W];

         hash_lo_ff <= pfh_pkg::HASH_ROM[ix_lo];
         hash_hi_ff <= pfh_pkg::HASH_ROM[ix_hi];
         iy3_ff     <= pos_y_ff[pfh_pkg::POS_W-1:pfh_pkg::FRAC_W];
         tx3_ff     <= pos_x_ff[pfh_pkg::FRAC_W-1:0];
         ty3_ff     <= pos_y_ff[pfh_pkg::FRAC_W-1:0];
         t2x3_ff    <= (2*pfh_pkg::FRAC_W)'(pos_x_ff[pfh_pkg::FRAC_W-1:0])
                       * (2*pfh_pkg::FRAC_W)'(pos_x_ff[pfh_pkg::FRAC_W-1:0]);
         t2y3_ff    <= (2*pfh_pkg::FRAC_W)'(pos_y_ff[pfh_pkg::FRAC_W-1:0])
                       * (2*pfh_pkg::FRAC_W)'(pos_y_ff[pfh_pkg::FRAC_W-1:0]);

         h00_ff <= pfh_pkg::HASH_ROM[8'(hash_lo_ff + iy_lo)];
         h10_ff <= pfh_pkg::HASH_ROM[8'(hash_hi_ff + iy_lo)];
         h01_ff <= pfh_pkg::HASH_ROM[8'(hash_lo_ff + iy_hi)];
         h11_ff <= pfh_pkg::HASH_ROM[8'(hash_hi_ff + iy_hi)];
         tx4_ff <= tx3_ff;
         ty4_ff <= ty3_ff;
         cx4_ff <= cube_x[CUBE_W-1:2*pfh_pkg::FRAC_W];
         cy4_ff <= cube_y[CUBE_W-1:2*pfh_pkg::FRAC_W];
         qx4_ff <= qf_x[pfh_pkg::FRAC_W +: pfh_pkg::Q_W];
         qy4_ff <= qf_y[pfh_pkg::FRAC_W +: pfh_pkg::Q_W];

         d00_ff <= corner_dot(h00_ff, dx0, dy0);
         d10_ff <= corner_dot(h10_ff, dx1, dy0);
         d01_ff <= corner_dot(h01_ff, dx0, dy1);
         d11_ff <= corner_dot(h11_ff, dx1, dy1);
         sx5_ff <= fade_x[pfh_pkg::FRAC_W +: pfh_pkg::FADE_W];
         sy5_ff <= fade_y[pfh_pkg::FRAC_W +: pfh_pkg::FADE_W];

         r0_ff  <= blend(d00_ff, d10_ff, sx5_ff);
         r1_ff  <= blend(d01_ff, d11_ff, sx5_ff);
         sy6_ff <= sy5_ff;

         noise_ff <= blend(r0_ff, r1_ff, sy6_ff);

         out_tok_ff <= out_tok_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_tok   = out_tok_ff;

endmodule

// ===== test/perlin_fbm_height_unit_test.sv =====
`timescale 1ns / 1ps

// Testbench for the fractal gradient noise height unit. An initial block runs a sequence of
// phases. All but the first program every register while the unit is idle; each phase then
// queues pixel coordinates. A clocked driver offers them in bursts, and a clocked monitor
// compares each accepted height with the prediction made when its request was accepted.
module perlin_fbm_height_unit_test;

   typedef struct packed {
      logic [pfh_pkg::COL_W-1:0] column;
      logic [pfh_pkg::ROW_W-1:0] row;
   } pixel_type;

   localparam int DRAIN_CYCLES = 90;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [pfh_pkg::COL_W-1:0]           req_column;
   logic [pfh_pkg::ROW_W-1:0]           req_row;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [pfh_pkg::HEIGHT_W-1:0] rsp_height;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [pfh_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [pfh_pkg::CSR_DATA_W-1:0]      csr_data;

   // The testbench's own copy of the register file, used by the height predictor.
   logic [pfh_pkg::SEED_W-1:0]     cur_seed;
   logic [pfh_pkg::FREQ_CFG_W-1:0] cur_freq;
   logic [pfh_pkg::AMP_W-1:0]      cur_amp;
   logic [pfh_pkg::AMP_W-1:0]      cur_pers;
   logic [pfh_pkg::COUNT_W-1:0]    cur_count;

   pixel_type                           pixels_to_send[$];
   logic signed [pfh_pkg::HEIGHT_W-1:0] heights_due[$];
   int                                  error_count = 0;
   int                                  heights_seen = 0;
   int                                  phase_count = 0;
   bit                                  hold_sender = 0;

   perlin_fbm_height_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_column(req_column), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_height(rsp_height),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The hash of a lattice corner: the permutation table is applied twice, first to the
   // x index offset by the seed and then to that result plus the y index.
   function automatic int corner_hash(input int ix, input int iy);
      int first;
      first = pfh_pkg::HASH_ROM[(ix + cur_seed) & 255];
      return pfh_pkg::HASH_ROM[(first + iy) & 255];
   endfunction

   // Dot product of the gradient picked by the hash with the offset from the corner.
   function automatic longint corner_dot(input int h, input longint dx, input longint dy);
      longint gx;
      longint gy;
      gx = 2 * longint'(h >> 4) - 1;
      gy = 2 * longint'(h & 15) - 1;
      return gx * dx + gy * dy;
   endfunction

   // Quintic fade 6t^5 - 15t^4 + 10t^3 in Q0.16, truncated exactly as the hardware does.
   function automatic longint quintic_fade(input longint unsigned t);
      longint unsigned q;
      longint unsigned c;
      q = ((64'd10 << 32) + 6 * t * t - 15 * t * 65536) >> 16;
      c = (t * t * t) >> 32;
      return longint'((c * q) >> 16);
   endfunction

   function automatic longint lerp_q16(input longint a, input longint b, input longint s);
      return a + ((s * (b - a)) >>> 16);
   endfunction

   // One octave of gradient noise in signed Q.16 at Q16.16 point (xq, yq), frequency Q.24.
   function automatic longint octave_noise(input longint unsigned xq, input longint unsigned yq,
                                           input longint unsigned f);
      longint unsigned px;
      longint unsigned py;
      int              ix;
      int              iy;
      longint          tx;
      longint          ty;
      longint          d00;
      longint          d10;
      longint          d01;
      longint          d11;
      longint          sx;
      longint          sy;
      px = (xq * f) >> 24;
      py = (yq * f) >> 24;
      ix = int'((px >> 16) & 255);
      iy = int'((py >> 16) & 255);
      tx = longint'(px & 16'hFFFF);
      ty = longint'(py & 16'hFFFF);
      d00 = corner_dot(corner_hash(ix, iy), tx, ty);
      d10 = corner_dot(corner_hash(ix + 1, iy), tx - 65536, ty);
      d01 = corner_dot(corner_hash(ix, iy + 1), tx, ty - 65536);
      d11 = corner_dot(corner_hash(ix + 1, iy + 1), tx - 65536, ty - 65536);
      sx = quintic_fade(tx);
      sy = quintic_fade(ty);
      return lerp_q16(lerp_q16(d00, d10, sx), lerp_q16(d01, d11, sx), sy);
   endfunction

   // Predicted height for one pixel under the current register settings.
   function automatic logic signed [pfh_pkg::HEIGHT_W-1:0] fbm_height(input pixel_type p);
      longint unsigned xq;
      longint unsigned yq;
      longint unsigned amp;
      longint          sum;
      int              octaves;
      xq = (longint'(p.column) << 16) | 64'h8000;
      yq = (longint'(p.row) << 16) | 64'h8000;
      octaves = (cur_count > pfh_pkg::MAX_OCTAVES) ? pfh_pkg::MAX_OCTAVES : int'(cur_count);
      amp = cur_amp;
      sum = 0;
      for (int i = 0; i < octaves; i++) begin
         sum += (longint'(amp) * octave_noise(xq, yq, longint'(cur_freq) << i)) >>> 15;
         amp = (amp * cur_pers) >> 15;
         if (amp > 65535) amp = 65535;
      end
      if (sum > 33554431) sum = 33554431;
      if (sum < -33554432) sum = -33554432;
      return sum[pfh_pkg::HEIGHT_W-1:0];
   endfunction

   // Driver: offers queued pixels in bursts of random length separated by random gaps.
   // A transaction that is offered stays on the port unchanged until it is accepted.
   int burst_left = 4;
   int gap_left   = 0;
   always @(posedge clock) begin
      pixel_type p;
      bit        take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = 1'b0;
         if (req_valid && !req_stall) begin
            p.column = req_column;
            p.row    = req_row;
            heights_due = {heights_due, fbm_height(p)};
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!hold_sender && pixels_to_send.size() > 0) begin
               take = 1'b1;
               p = pixels_to_send.pop_front();
               req_column <= p.column;
               req_row    <= p.row;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
            req_valid <= take;
         end
      end
   end

   // Monitor: checks each accepted height against the oldest prediction. The response
   // stall follows a mode that is picked anew at random intervals: none, light, heavy, periodic.
   int stall_mode  = 0;
   int mode_cycles = 0;
   int cycle_index = 0;
   always @(posedge clock) begin
      logic signed [pfh_pkg::HEIGHT_W-1:0] want;
      cycle_index++;
      if (rsp_valid && !rsp_stall && !reset) begin
         heights_seen++;
         if (heights_due.size() == 0) begin
            error_count++;
            $display("%0t: height %0d arrived with no request outstanding", $realtime,
                     rsp_height);
         end else begin
            want = heights_due.pop_front();
            if (want !== rsp_height) begin
               error_count++;
               $display("%0t: height mismatch, expected %0d, actual %0d", $realtime,
                        want, rsp_height);
            end
         end
      end
      if (mode_cycles <= 0) begin
         stall_mode  = $urandom_range(0, 3);
         mode_cycles = $urandom_range(20, 120);
      end
      mode_cycles--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (cycle_index % 5 < 2);
      endcase
   end

   // Waits until the sender has nothing left, every height has come back and the pipeline
   // has had time to empty.
   task automatic wait_idle();
      do @(posedge clock);
      while (pixels_to_send.size() != 0 || req_valid || heights_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Presents one register write and waits for its handshake. The caller drops the valid
   // after the last write of a group.
   task automatic write_reg(input logic [pfh_pkg::CSR_INDEX_W-1:0] index,
                            input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[pfh_pkg::CSR_DATA_W-1:0];
      do @(posedge clock);
      while (!csr_ready);
      case (index)
         pfh_pkg::CSR_SEED:           cur_seed  = value[pfh_pkg::SEED_W-1:0];
         pfh_pkg::CSR_BASE_FREQUENCY: cur_freq  = value[pfh_pkg::FREQ_CFG_W-1:0];
         pfh_pkg::CSR_BASE_AMPLITUDE: cur_amp   = value[pfh_pkg::AMP_W-1:0];
         pfh_pkg::CSR_PERSISTENCE:    cur_pers  = value[pfh_pkg::AMP_W-1:0];
         default:                     cur_count = value[pfh_pkg::COUNT_W-1:0];
      endcase
   endtask

   // Programs a full register setting once the unit is idle. The queued pixels go out
   // first; holding the sender across the writes then gives the pause in which every
   // outstanding height comes back.
   task automatic program_all(input int unsigned s, input int unsigned f, input int unsigned a,
                              input int unsigned pe, input int unsigned c);
      wait (pixels_to_send.size() == 0);
      hold_sender = 1'b1;
      wait_idle();
      write_reg(pfh_pkg::CSR_SEED, s);
      write_reg(pfh_pkg::CSR_BASE_FREQUENCY, f);
      write_reg(pfh_pkg::CSR_BASE_AMPLITUDE, a);
      write_reg(pfh_pkg::CSR_PERSISTENCE, pe);
      write_reg(pfh_pkg::CSR_OCTAVE_COUNT, c);
      csr_valid <= 1'b0;
      phase_count++;
      hold_sender = 1'b0;
   endtask

   task automatic queue_pixel(input int unsigned c, input int unsigned r);
      pixel_type p;
      p.column = c[pfh_pkg::COL_W-1:0];
      p.row    = r[pfh_pkg::ROW_W-1:0];
      pixels_to_send = {pixels_to_send, p};
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++) queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
   endtask

   task automatic queue_corners();
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);
      queue_pixel(0, 4095);
      queue_pixel(4095, 0);
   endtask

   initial begin
      int unsigned freq;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_column = '0;
      req_row    = '0;
      rsp_stall  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      cur_seed   = pfh_pkg::SEED_RESET;
      cur_freq   = pfh_pkg::BASE_FREQUENCY_RESET;
      cur_amp    = pfh_pkg::BASE_AMPLITUDE_RESET;
      cur_pers   = pfh_pkg::PERSISTENCE_RESET;
      cur_count  = pfh_pkg::OCTAVE_COUNT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: field extremes, alternating bit patterns and neighbors that share
      // a lattice cell.
      queue_corners();
      queue_pixel(12'hAAA, 12'h555);
      queue_pixel(12'h555, 12'hAAA);
      queue_pixel(100, 100);
      queue_pixel(101, 100);
      queue_pixel(100, 101);

      // No octave summed, so every height must be zero.
      program_all(7, 167772, 26214, 22938, 0);
      queue_corners();
      // A count beyond the built size is clipped to the maximum number of octaves.
      program_all(255, 16777215, 65535, 32768, 15);
      queue_corners();
      queue_pixel(12'hAAA, 12'h555);
      // Zero base frequency samples the lattice origin in every octave.
      program_all(33, 0, 65535, 65535, 8);
      queue_pixel(4095, 17);
      queue_pixel(1234, 4095);
      // Amplitude saturation with persistence above one, and a sum that can hit the ends.
      program_all(91, 3000000, 65535, 65535, 8);
      queue_random(6);
      // Smallest frequency and amplitude, with a high frequency that wraps the lattice.
      program_all(0, 1, 0, 0, 1);
      queue_corners();
      program_all(200, 8000000, 1, 65535, 8);
      queue_random(4);

      // Random settings: the frequency spans many octaves of magnitude so that both the
      // smooth and the aliased regimes of the noise are reached.
      for (int ph = 0; ph < 9; ph++) begin
         freq = $urandom_range(1, 16777215) >> $urandom_range(0, 23);
         if (freq == 0) freq = 1;
         program_all($urandom_range(0, 255), freq, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(1, 8));
         queue_random(95);
      end

      hold_sender = 1'b0;
      wait_idle();
      $display("Covered %0d register settings and %0d heights, with count, frequency,",
               phase_count, heights_seen);
      $display("amplitude and saturation corners under bursty input and stalled output.");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
